// File: hw/rtl/key_value_map_table_macros.svh
// ============================================================================
// key_value_map_table_macros: assertion helpers for the key-value table
// Shared property wrappers; each expects clk and rst_n in scope.
// ============================================================================
`ifndef KEY_VALUE_MAP_TABLE_MACROS_SVH
`define KEY_VALUE_MAP_TABLE_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define KVMT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key_value_map_table: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define KVMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key_value_map_table: next-cycle check failed");

`endif

// File: hw/rtl/kvmt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// kvmt_pkg: shared types and constants of the key-value table
// Opcodes, payload structs and the stored slot format.
// ============================================================================
package kvmt_pkg;

    // Opcodes of an input item
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Reset value of the null value register (-111111)
    localparam logic signed [31:0] NULL_RESET = 32'shFFFE4DF9;

    // Width of the reported entry count
    localparam int unsigned ENTRY_COUNT_W = 5;

    typedef struct packed {
        logic        [1:0]  opcode;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } kvmt_in_t;

    typedef struct packed {
        logic signed [31:0]              result_value;
        logic                            hit;
        logic [ENTRY_COUNT_W-1:0]        entry_count;
        logic                            full_error;
    } kvmt_out_t;

    // One stored slot: valid flag, key and value
    typedef struct packed {
        logic               valid;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } kvmt_slot_t;

endpackage

// File: hw/rtl/key_value_map_table.sv
`timescale 1ns / 1ps
// ============================================================================
// key_value_map_table: bounded key-value table with add, search and remove
// Top level: null value register, slot memory and scan sequencer.
// ============================================================================
// After reset the table runs a clearing pass over the slot memory and
// takes no item meanwhile; null value writes are taken at any time.
// Each item then occupies the block from transfer to result: one slot is
// read from the slot memory per cycle and checked by one shared key
// comparator, followed by a compare of the last slot and a write-back that
// waits until the output register is free. The input stalls for the whole
// operation and is free again in the cycle after the result is registered.
// The finished result sits in an output register, so the next item is taken
// while it waits. A new key goes into the lowest free slot; an add of a new
// key to a full table changes nothing and reports full_error.
module key_value_map_table #(
    parameter int CAPACITY = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  kvmt_pkg::kvmt_in_t        in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output kvmt_pkg::kvmt_out_t       out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic signed [31:0]        cfg_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [31:0]       null_value_reg;
    logic                     mem_wr_en;
    logic [IDX_W-1:0]         mem_wr_addr;
    kvmt_pkg::kvmt_slot_t     mem_wr_data;
    logic                     mem_rd_en;
    logic [IDX_W-1:0]         mem_rd_addr;
    kvmt_pkg::kvmt_slot_t     mem_rd_data;

    assign cfg_ready = 1'b1;

    // Hold the null value, update it on each configuration transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            null_value_reg <= kvmt_pkg::NULL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            null_value_reg <= cfg_data;
        end
    end

    kvmt_slot_mem #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_slot_mem (
        .clk      (clk),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_data  (mem_rd_data)
    );

    kvmt_seq #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .null_value  (null_value_reg),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

endmodule

// File: hw/rtl/kvmt_slot_mem.sv
`timescale 1ns / 1ps
// ============================================================================
// kvmt_slot_mem: slot storage of the key-value table
// One write port and one registered read port over CAPACITY slots.
// ============================================================================
module kvmt_slot_mem #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_addr,
    input  kvmt_pkg::kvmt_slot_t      wr_data,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output kvmt_pkg::kvmt_slot_t      rd_data
);

    kvmt_pkg::kvmt_slot_t mem [CAPACITY];
    kvmt_pkg::kvmt_slot_t rd_data_reg;

    // Write one slot, read one slot into the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/kvmt_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// kvmt_seq: sequencer of the key-value table
// Clears the slots after reset, scans every slot through one key comparator,
// then writes back if the item changes a slot and registers the result.
// ============================================================================
`include "key_value_map_table_macros.svh"

module kvmt_seq #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  kvmt_pkg::kvmt_in_t        in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output kvmt_pkg::kvmt_out_t       out_data,
    input  logic signed [31:0]        null_value,
    output logic                      mem_wr_en,
    output logic [IDX_W-1:0]          mem_wr_addr,
    output kvmt_pkg::kvmt_slot_t      mem_wr_data,
    output logic                      mem_rd_en,
    output logic [IDX_W-1:0]          mem_rd_addr,
    input  kvmt_pkg::kvmt_slot_t      mem_rd_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         addr_reg, addr_next;
    logic [IDX_W-1:0]         chk_reg, chk_next;
    logic                     issue_reg, issue_next;
    logic                     pend_reg, pend_next;
    kvmt_pkg::kvmt_in_t       item_reg, item_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         found_idx_reg, found_idx_next;
    logic signed [31:0]       found_val_reg, found_val_next;
    logic                     free_any_reg, free_any_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;
    kvmt_pkg::kvmt_out_t      out_reg, out_next;

    logic                     in_take;
    logic                     out_free;
    logic                     slot_match;
    logic                     slot_free;
    logic signed [31:0]       res_val;
    logic                     res_hit;
    logic                     res_full;
    logic [CNT_W+kvmt_pkg::ENTRY_COUNT_W-1:0] count_wide;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Shared comparator on the slot read back this cycle
    assign slot_match = pend_reg && mem_rd_data.valid && (mem_rd_data.key == item_reg.key);
    assign slot_free  = pend_reg && !mem_rd_data.valid;

    // Sequencer next-state and write-back logic
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        chk_next       = chk_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        item_next      = item_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        found_val_next = found_val_reg;
        free_any_next  = free_any_reg;
        free_idx_next  = free_idx_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = found_idx_reg;
        mem_wr_data = '{valid: 1'b1, key: item_reg.key, value: item_reg.value};
        mem_rd_en   = 1'b0;
        mem_rd_addr = addr_reg;

        res_val    = null_value;
        res_hit    = 1'b0;
        res_full   = 1'b0;
        count_wide = '0;

        // Drop the result once the consumer takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Invalidate one slot per cycle
                mem_wr_en   = 1'b1;
                mem_wr_addr = addr_reg;
                mem_wr_data = '{valid: 1'b0, key: '0, value: '0};
                addr_next   = IDX_W'(addr_reg + 1'b1);
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // Latch the item and start the scan
                if (in_take)
                begin
                    item_next     = in_data;
                    addr_next     = '0;
                    issue_next    = 1'b1;
                    pend_next     = 1'b0;
                    found_next    = 1'b0;
                    free_any_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle and compare the previous one
                mem_rd_en = issue_reg;
                if (issue_reg)
                begin
                    addr_next  = IDX_W'(addr_reg + 1'b1);
                    issue_next = (addr_reg != LAST_IDX);
                end
                pend_next = issue_reg;
                chk_next  = addr_reg;
                if (slot_match)
                begin
                    found_next     = 1'b1;
                    found_idx_next = chk_reg;
                    found_val_next = mem_rd_data.value;
                end
                if (slot_free && !free_any_reg)
                begin
                    free_any_next = 1'b1;
                    free_idx_next = chk_reg;
                end
                if (pend_reg && (chk_reg == LAST_IDX))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // Write back and register the result when the output is free
                if (out_free)
                begin
                    case (item_reg.opcode)
                        kvmt_pkg::OP_ADD:
                        begin
                            if (found_reg)
                            begin
                                res_val   = found_val_reg;
                                res_hit   = 1'b1;
                                mem_wr_en = 1'b1;
                            end
                            else if (free_any_reg)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = free_idx_reg;
                                count_next  = CNT_W'(count_reg + 1'b1);
                            end
                            else
                            begin
                                res_full = 1'b1;
                            end
                        end
                        kvmt_pkg::OP_SEARCH:
                        begin
                            if (found_reg)
                            begin
                                res_val = found_val_reg;
                                res_hit = 1'b1;
                            end
                        end
                        kvmt_pkg::OP_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                res_val           = found_val_reg;
                                res_hit           = 1'b1;
                                mem_wr_en         = 1'b1;
                                mem_wr_data.valid = 1'b0;
                                if (count_reg != '0)
                                begin
                                    count_next = CNT_W'(count_reg - 1'b1);
                                end
                            end
                        end
                        default:
                        begin
                            res_val = null_value;
                        end
                    endcase
                    count_wide     = {{kvmt_pkg::ENTRY_COUNT_W{1'b0}}, count_next};
                    out_next       = '{result_value: res_val,
                                       hit:          res_hit,
                                       entry_count:  count_wide[kvmt_pkg::ENTRY_COUNT_W-1:0],
                                       full_error:   res_full};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, scan context and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            chk_reg       <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            free_any_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            chk_reg       <= chk_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            free_any_reg  <= free_any_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        found_idx_reg <= found_idx_next;
        found_val_reg <= found_val_next;
        free_idx_reg  <= free_idx_next;
        out_reg       <= out_next;
    end

    `KVMT_ASSERT_IMP(a_count_max, 1'b1, count_reg <= CAP_CNT)
    `KVMT_ASSERT_IMP(a_full_no_hit, out_valid_reg, !(out_reg.full_error && out_reg.hit))
    `KVMT_ASSERT_IMP(a_full_at_cap, out_valid_reg && out_reg.full_error, count_reg == CAP_CNT)
    `KVMT_ASSERT_NEXT(a_add_new_count,
        (state_reg == ST_DECIDE) && out_free && (item_reg.opcode == kvmt_pkg::OP_ADD)
            && !found_reg && free_any_reg,
        count_reg == CNT_W'($past(count_reg) + 1'b1))

endmodule
